@@ src/evfg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_pkg
// Shared types, constants and register codes of the energy frame gate.
// ----------------------------------------------------------------------------
package evfg_pkg;

  localparam int unsigned FRAME_SAMPLES = 256;
  localparam int unsigned PREROLL_DEPTH = 16;
  localparam int unsigned CNT_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W         = 24;
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FPTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FCNT_W        = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned STEP_W        = $clog2(SUM_W);
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [9:0] CNT_SAT = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREROLL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH       = 3'd5;

  localparam logic [15:0] RST_THRESHOLD   = 16'd500;
  localparam logic [4:0]  RST_PREROLL     = 5'd10;
  localparam logic [9:0]  RST_SILENCE_LIM = 10'd50;
  localparam logic [9:0]  RST_MAX_FRAMES  = 10'd375;
  localparam logic [9:0]  RST_MIN_SPEECH  = 10'd3;
  localparam logic [7:0]  RST_FLUSH       = 8'd60;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_REC   = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_BUSY = 2'd1,
    DIV_DONE = 2'd2
  } div_state_e;

  localparam logic [2:0] EV_IDLE    = 3'd0;
  localparam logic [2:0] EV_START   = 3'd1;
  localparam logic [2:0] EV_REC     = 3'd2;
  localparam logic [2:0] EV_END_SIL = 3'd3;
  localparam logic [2:0] EV_END_MAX = 3'd4;
  localparam logic [2:0] EV_FLUSH   = 3'd5;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_in_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] frame_energy;
    logic        is_speech;
    logic        keep_frame;
    logic [3:0]  ring_slot;
    logic [4:0]  preroll_count;
    logic [3:0]  oldest_slot;
    logic [9:0]  recorded_count;
    logic [9:0]  speech_count;
    logic        accepted;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [15:0] energy_threshold;
    logic [4:0]  preroll_frames;
    logic [9:0]  silence_limit;
    logic [9:0]  max_frames;
    logic [9:0]  min_speech;
    logic [7:0]  flush_frames;
  } cfg_t;

endpackage

@@ src/evfg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_front
// Sample accumulator: sums magnitudes, counts samples, emits one frame record.
// ----------------------------------------------------------------------------
module evfg_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  evfg_pkg::in_t         in_data_i,
  input  evfg_pkg::fifo_stat_t  fifo_stat_i,
  output logic                  push_o,
  output evfg_pkg::frame_t      push_data_o
);

  logic [evfg_pkg::SUM_W-1:0] sum_q, sum_d, sum_n;
  logic [evfg_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic [15:0]                mag;
  logic                       accept;
  logic                       frame_end;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mag       = in_data_i.sample[15] ? 16'(~in_data_i.sample + 16'sd1)
                                     : 16'(in_data_i.sample);
    sum_n     = sum_q + evfg_pkg::SUM_W'(mag);
    cnt_n     = cnt_q + 1'b1;
    frame_end = in_data_i.last_in_frame ||
                (cnt_n == evfg_pkg::CNT_W'(evfg_pkg::FRAME_SAMPLES));
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    if (accept) begin
      if (frame_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_n;
        cnt_d = cnt_n;
      end
    end
  end

  assign push_o           = accept && frame_end;
  assign push_data_o.sum  = sum_n;
  assign push_data_o.cnt  = cnt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/evfg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_fifo
// Short queue of finished frame records between accumulator and divider.
// ----------------------------------------------------------------------------
module evfg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  evfg_pkg::frame_t      push_data_i,
  input  logic                  pop_i,
  output evfg_pkg::frame_t      pop_data_o,
  output evfg_pkg::fifo_stat_t  stat_o
);

  evfg_pkg::frame_t              mem_q [evfg_pkg::FIFO_DEPTH];
  logic [evfg_pkg::FPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [evfg_pkg::FCNT_W-1:0]   cnt_q, cnt_d;

  function automatic logic [evfg_pkg::FPTR_W-1:0] ptr_inc(
    input logic [evfg_pkg::FPTR_W-1:0] p
  );
    if (p == evfg_pkg::FPTR_W'(evfg_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == evfg_pkg::FCNT_W'(evfg_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ src/evfg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_div
// Restoring divider, one quotient bit per cycle: frame mean = sum / count.
// ----------------------------------------------------------------------------
module evfg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  evfg_pkg::frame_t  frame_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [15:0]       energy_o,
  input  logic              ack_i
);

  evfg_pkg::div_state_e          state_q, state_d;
  logic [evfg_pkg::SUM_W-1:0]    quo_q, quo_d;
  logic [evfg_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [evfg_pkg::CNT_W-1:0]    dsr_q, dsr_d;
  logic [evfg_pkg::STEP_W-1:0]   step_q, step_d;
  logic [evfg_pkg::CNT_W:0]      trial;
  logic                          ge;
  logic                          last_step;

  assign last_step = (step_q == evfg_pkg::STEP_W'(evfg_pkg::SUM_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      evfg_pkg::DIV_IDLE: if (avail_i)   state_d = evfg_pkg::DIV_BUSY;
      evfg_pkg::DIV_BUSY: if (last_step) state_d = evfg_pkg::DIV_DONE;
      evfg_pkg::DIV_DONE: if (ack_i)     state_d = evfg_pkg::DIV_IDLE;
      default:                           state_d = evfg_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    done_o = 1'b0;
    case (state_q)
      evfg_pkg::DIV_IDLE: pop_o  = avail_i;
      evfg_pkg::DIV_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    trial  = {rem_q, quo_q[evfg_pkg::SUM_W-1]};
    ge     = (trial >= {1'b0, dsr_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    if (pop_o) begin
      quo_d  = frame_i.sum;
      dsr_d  = frame_i.cnt;
      rem_d  = '0;
      step_d = '0;
    end else if (state_q == evfg_pkg::DIV_BUSY) begin
      rem_d  = evfg_pkg::CNT_W'(ge ? trial - {1'b0, dsr_q} : trial);
      quo_d  = {quo_q[evfg_pkg::SUM_W-2:0], ge};
      step_d = step_q + 1'b1;
    end
  end

  assign energy_o = quo_q[15:0];

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evfg_pkg::DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/evfg_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evfg_decide
// Per-frame gate: speech test, pre-roll ring, recording counts, result register.
// ----------------------------------------------------------------------------
module evfg_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  evfg_pkg::cfg_t  cfg_i,
  input  logic            done_i,
  input  logic [15:0]     energy_i,
  output logic            ack_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output evfg_pkg::res_t  out_data_o
);

  evfg_pkg::mode_e  mode_q, mode_d;
  logic [3:0]       rp_q, rp_d;
  logic [4:0]       fill_q, fill_d;
  logic [9:0]       rec_q, rec_d;
  logic [9:0]       sil_q, sil_d;
  logic [9:0]       spf_q, spf_d;
  logic [7:0]       fl_q, fl_d;
  logic             out_valid_q, out_valid_d;
  evfg_pkg::res_t   res_q, res_d;

  logic        speech;
  logic [4:0]  plen;
  logic [3:0]  slot;
  logic [3:0]  next_slot;
  logic [4:0]  slot_inc;
  logic [4:0]  fill_c;
  logic [4:0]  fill_n;
  logic        keep_rec;
  logic [9:0]  rec_n;
  logic [9:0]  spf_n;
  logic [9:0]  sil_n;
  logic        hit_sil;
  logic        hit_max;
  logic        acc;
  logic [7:0]  fl_n;

  function automatic logic [9:0] sat_inc(input logic [9:0] v);
    return (v >= evfg_pkg::CNT_SAT) ? evfg_pkg::CNT_SAT : v + 10'd1;
  endfunction

  assign ack_o = done_i && (!out_valid_q || out_ready_i);

  always_comb begin
    speech = (energy_i > cfg_i.energy_threshold);
    if (cfg_i.preroll_frames == 5'd0) begin
      plen = 5'd1;
    end else if (cfg_i.preroll_frames > 5'(evfg_pkg::PREROLL_DEPTH)) begin
      plen = 5'(evfg_pkg::PREROLL_DEPTH);
    end else begin
      plen = cfg_i.preroll_frames;
    end
    slot      = ({1'b0, rp_q} < plen) ? rp_q : 4'd0;
    slot_inc  = {1'b0, slot} + 5'd1;
    next_slot = (slot_inc >= plen) ? 4'd0 : slot_inc[3:0];
    fill_c    = (fill_q > plen) ? plen : fill_q;
    fill_n    = (fill_c < plen) ? fill_c + 5'd1 : fill_c;
    keep_rec  = (rec_q < cfg_i.max_frames);
    rec_n     = keep_rec ? sat_inc(rec_q) : rec_q;
    spf_n     = speech ? sat_inc(spf_q) : spf_q;
    sil_n     = speech ? 10'd0 : sat_inc(sil_q);
    hit_sil   = (sil_n >= cfg_i.silence_limit);
    hit_max   = (rec_n >= cfg_i.max_frames);
    acc       = (spf_n >= cfg_i.min_speech);
    fl_n      = (fl_q != 8'd0) ? fl_q - 8'd1 : fl_q;
  end

  always_comb begin
    mode_d = mode_q;
    if (ack_o) begin
      case (mode_q)
        evfg_pkg::MODE_REC: begin
          if (hit_sil || hit_max) begin
            mode_d = (acc && cfg_i.flush_frames != 8'd0) ? evfg_pkg::MODE_FLUSH
                                                         : evfg_pkg::MODE_IDLE;
          end
        end
        evfg_pkg::MODE_FLUSH: begin
          if (fl_n == 8'd0) mode_d = evfg_pkg::MODE_IDLE;
        end
        default: begin
          mode_d = speech ? evfg_pkg::MODE_REC : evfg_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rp_d   = rp_q;
    fill_d = fill_q;
    rec_d  = rec_q;
    sil_d  = sil_q;
    spf_d  = spf_q;
    fl_d   = fl_q;
    res_d  = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ack_o) begin
      out_valid_d        = 1'b1;
      res_d              = '0;
      res_d.frame_energy = energy_i;
      res_d.is_speech    = speech;
      case (mode_q)
        evfg_pkg::MODE_REC: begin
          res_d.keep_frame     = keep_rec;
          res_d.recorded_count = rec_n;
          res_d.speech_count   = spf_n;
          rec_d = rec_n;
          spf_d = spf_n;
          sil_d = sil_n;
          if (hit_sil || hit_max) begin
            res_d.event_res = hit_max ? evfg_pkg::EV_END_MAX : evfg_pkg::EV_END_SIL;
            res_d.accepted  = acc;
            rp_d   = '0;
            fill_d = '0;
            rec_d  = '0;
            sil_d  = '0;
            spf_d  = '0;
            if (acc && cfg_i.flush_frames != 8'd0) fl_d = cfg_i.flush_frames;
          end else begin
            res_d.event_res = evfg_pkg::EV_REC;
          end
        end
        evfg_pkg::MODE_FLUSH: begin
          res_d.event_res = evfg_pkg::EV_FLUSH;
          fl_d = fl_n;
        end
        default: begin
          rp_d            = next_slot;
          fill_d          = fill_n;
          res_d.ring_slot = slot;
          res_d.event_res = evfg_pkg::EV_IDLE;
          if (speech) begin
            res_d.event_res      = evfg_pkg::EV_START;
            res_d.keep_frame     = 1'b1;
            res_d.preroll_count  = fill_n;
            res_d.oldest_slot    = (fill_n >= plen) ? next_slot : 4'd0;
            rec_d = ({5'd0, fill_n} < cfg_i.max_frames) ? {5'd0, fill_n}
                                                        : cfg_i.max_frames;
            spf_d = 10'd1;
            sil_d = 10'd0;
            res_d.recorded_count = rec_d;
            res_d.speech_count   = 10'd1;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= evfg_pkg::MODE_IDLE;
      rp_q        <= '0;
      fill_q      <= '0;
      rec_q       <= '0;
      sil_q       <= '0;
      spf_q       <= '0;
      fl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      rec_q       <= rec_d;
      sil_q       <= sil_d;
      spf_q       <= spf_d;
      fl_q        <= fl_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/energy_vad_frame_gate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_vad_frame_gate
// Frame-energy voice activity gate with pre-roll ring tracking and flush.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the frame queue is not full. A frame
// ends on last_in_frame or on the 256th sample and gives exactly one result;
// other samples give none. Each frame record waits in a two-entry queue for a
// bit-serial divider, which pops a record while idle and holds the mean until
// it is handed over; long frames stream at the full sample rate, while runs of
// shorter frames are held back by the divider through the full queue. A result
// waits in an output register without blocking accumulation of the next frame.
// Configuration writes are single-cycle and must be made while idle.
module energy_vad_frame_gate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  evfg_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output evfg_pkg::res_t                        out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [evfg_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [evfg_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  evfg_pkg::cfg_t        cfg_q, cfg_d;
  evfg_pkg::fifo_stat_t  fifo_stat;
  evfg_pkg::frame_t      push_data;
  evfg_pkg::frame_t      pop_data;
  logic                  push;
  logic                  pop;
  logic                  div_done;
  logic                  div_ack;
  logic [15:0]           energy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        evfg_pkg::REG_THRESHOLD:   cfg_d.energy_threshold = cfg_wdata_i[15:0];
        evfg_pkg::REG_PREROLL:     cfg_d.preroll_frames   = cfg_wdata_i[4:0];
        evfg_pkg::REG_SILENCE_LIM: cfg_d.silence_limit    = cfg_wdata_i[9:0];
        evfg_pkg::REG_MAX_FRAMES:  cfg_d.max_frames       = cfg_wdata_i[9:0];
        evfg_pkg::REG_MIN_SPEECH:  cfg_d.min_speech       = cfg_wdata_i[9:0];
        evfg_pkg::REG_FLUSH:       cfg_d.flush_frames     = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.energy_threshold <= evfg_pkg::RST_THRESHOLD;
      cfg_q.preroll_frames   <= evfg_pkg::RST_PREROLL;
      cfg_q.silence_limit    <= evfg_pkg::RST_SILENCE_LIM;
      cfg_q.max_frames       <= evfg_pkg::RST_MAX_FRAMES;
      cfg_q.min_speech       <= evfg_pkg::RST_MIN_SPEECH;
      cfg_q.flush_frames     <= evfg_pkg::RST_FLUSH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  evfg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  evfg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  evfg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (!fifo_stat.empty),
    .frame_i  (pop_data),
    .pop_o    (pop),
    .done_o   (div_done),
    .energy_o (energy),
    .ack_i    (div_ack)
  );

  evfg_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .done_i      (div_done),
    .energy_i    (energy),
    .ack_o       (div_ack),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !push)
    else $error("frame record pushed into full queue");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("divider popped empty queue");

  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == evfg_pkg::EV_START)
      |-> out_data_o.keep_frame && (out_data_o.preroll_count != 5'd0)
          && out_data_o.is_speech)
    else $error("speech start result without kept frame or pre-roll");

  a_accept_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted
      |-> (out_data_o.event_res == evfg_pkg::EV_END_SIL) ||
          (out_data_o.event_res == evfg_pkg::EV_END_MAX))
    else $error("accepted flag outside end of recording");
`endif

endmodule

@@ bench/tb_energy_vad_frame_gate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_energy_vad_frame_gate
// Self-checking bench for the energy frame gate. Samples stream through the
// valid/ready input with random gaps while the result side stalls at random.
// A cycle-free model of the gate predicts one result per completed frame, and
// each result transfer is compared field by field against the oldest
// prediction. A short table of hand-picked samples runs at reset settings,
// then phases of bursty speech/silence frames run under several register sets.
// ----------------------------------------------------------------------------
module tb_energy_vad_frame_gate;

  typedef enum int {K_QUIET, K_LOUD, K_EDGE_LO, K_EDGE_HI, K_NOISE} frame_kind_e;

  typedef struct {
    evfg_pkg::in_t  item;
    bit             typed;
    evfg_pkg::res_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 11;
  localparam int FIXED_PHASES = 7;
  localparam int PHASES = 9;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready_o;
  evfg_pkg::in_t                   in_data = '0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  evfg_pkg::res_t                  out_data_o;
  logic                            cfg_we = 1'b0;
  logic [evfg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [evfg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // gate model state
  evfg_pkg::cfg_t  cfg_cur;
  evfg_pkg::mode_e gate_mode;
  logic [23:0]     acc_sum;
  logic [8:0]      acc_cnt;
  logic [3:0]      ring_ptr;
  logic [4:0]      ring_fill;
  logic [9:0]      rec_frames;
  logic [9:0]      sil_run;
  logic [9:0]      spk_frames;
  logic [7:0]      flush_left;

  evfg_pkg::res_t frame_results_q[$];
  int   mismatches = 0;
  int   res_count = 0;
  int   tx_calm = 0;
  int   rx_calm = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{16'sd0, 1'b1}, 1'b1,
      '{evfg_pkg::EV_IDLE, 16'd0, 1'b0, 1'b0, 4'd0, 5'd0, 4'd0, 10'd0, 10'd0, 1'b0}},
    '{'{16'sd500, 1'b0}, 1'b0, '0},
    '{'{16'sd500, 1'b1}, 1'b1,
      '{evfg_pkg::EV_IDLE, 16'd500, 1'b0, 1'b0, 4'd1, 5'd0, 4'd0, 10'd0, 10'd0, 1'b0}},
    '{'{-16'sd501, 1'b1}, 1'b1,
      '{evfg_pkg::EV_START, 16'd501, 1'b1, 1'b1, 4'd2, 5'd3, 4'd0, 10'd3, 10'd1, 1'b0}},
    '{'{-16'sd32768, 1'b1}, 1'b1,
      '{evfg_pkg::EV_REC, 16'd32768, 1'b1, 1'b1, 4'd0, 5'd0, 4'd0, 10'd4, 10'd2, 1'b0}},
    '{'{16'sd32767, 1'b0}, 1'b0, '0},
    '{'{-16'sd32768, 1'b1}, 1'b0, '0},
    '{'{16'sd0, 1'b1}, 1'b0, '0},
    '{'{16'sd1, 1'b0}, 1'b0, '0},
    '{'{-16'sd1, 1'b0}, 1'b0, '0},
    '{'{16'sd0, 1'b1}, 1'b0, '0}
  };

  evfg_pkg::cfg_t phase_cfg [FIXED_PHASES] = '{
    '{16'd1000,  5'd4,  10'd2,    10'd16,   10'd2,    8'd3},
    '{16'd0,     5'd16, 10'd1,    10'd16,   10'd0,    8'd0},
    '{16'd32768, 5'd1,  10'd1023, 10'd1023, 10'd1023, 8'd255},
    '{16'd2000,  5'd0,  10'd0,    10'd0,    10'd1,    8'd1},
    '{16'd300,   5'd31, 10'd3,    10'd20,   10'd4,    8'd2},
    '{16'd8000,  5'd7,  10'd2,    10'd30,   10'd1,    8'd5},
    '{16'd500,   5'd3,  10'd4,    10'd16,   10'd3,    8'd1}
  };

  energy_vad_frame_gate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [9:0] sat_up(input logic [9:0] v);
    return (v >= evfg_pkg::CNT_SAT) ? evfg_pkg::CNT_SAT : v + 10'd1;
  endfunction

  // Advance the gate model by one sample; return 1 when a frame closes.
  function automatic bit gate_frame_step(input evfg_pkg::in_t d, output evfg_pkg::res_t r);
    int mag, energy, plen, slot, nxt;
    bit speech, hit_sil, hit_max;
    r = '0;
    mag = (d.sample < 0) ? -int'(d.sample) : int'(d.sample);
    acc_sum = acc_sum + 24'(mag);
    acc_cnt = acc_cnt + 9'd1;
    if (!d.last_in_frame && acc_cnt < evfg_pkg::FRAME_SAMPLES) return 1'b0;
    energy = (acc_cnt != 0) ? int'(acc_sum) / int'(acc_cnt) : 0;
    acc_sum = '0;
    acc_cnt = '0;
    speech = energy > int'(cfg_cur.energy_threshold);
    r.frame_energy = 16'(energy);
    r.is_speech = speech;
    case (gate_mode)
      evfg_pkg::MODE_REC: begin
        if (rec_frames < cfg_cur.max_frames) begin
          r.keep_frame = 1'b1;
          rec_frames = sat_up(rec_frames);
        end
        if (speech) spk_frames = sat_up(spk_frames);
        sil_run = speech ? 10'd0 : sat_up(sil_run);
        hit_sil = sil_run >= cfg_cur.silence_limit;
        hit_max = rec_frames >= cfg_cur.max_frames;
        r.recorded_count = rec_frames;
        r.speech_count = spk_frames;
        if (hit_sil || hit_max) begin
          r.event_res = hit_max ? evfg_pkg::EV_END_MAX : evfg_pkg::EV_END_SIL;
          r.accepted = spk_frames >= cfg_cur.min_speech;
          ring_ptr = '0;
          ring_fill = '0;
          rec_frames = '0;
          sil_run = '0;
          spk_frames = '0;
          if (r.accepted && cfg_cur.flush_frames != 0) begin
            gate_mode = evfg_pkg::MODE_FLUSH;
            flush_left = cfg_cur.flush_frames;
          end else begin
            gate_mode = evfg_pkg::MODE_IDLE;
          end
        end else begin
          r.event_res = evfg_pkg::EV_REC;
        end
      end
      evfg_pkg::MODE_FLUSH: begin
        r.event_res = evfg_pkg::EV_FLUSH;
        if (flush_left != 0) flush_left = flush_left - 8'd1;
        if (flush_left == 0) gate_mode = evfg_pkg::MODE_IDLE;
      end
      default: begin
        plen = int'(cfg_cur.preroll_frames);
        if (plen < 1) plen = 1;
        if (plen > evfg_pkg::PREROLL_DEPTH) plen = evfg_pkg::PREROLL_DEPTH;
        slot = (ring_ptr < plen) ? int'(ring_ptr) : 0;
        nxt = (slot + 1 >= plen) ? 0 : slot + 1;
        ring_ptr = 4'(nxt);
        if (ring_fill > plen) ring_fill = 5'(plen);
        if (ring_fill < plen) ring_fill = ring_fill + 5'd1;
        r.ring_slot = 4'(slot);
        r.event_res = evfg_pkg::EV_IDLE;
        if (speech) begin
          r.event_res = evfg_pkg::EV_START;
          gate_mode = evfg_pkg::MODE_REC;
          r.keep_frame = 1'b1;
          r.preroll_count = ring_fill;
          r.oldest_slot = (ring_fill >= plen) ? 4'(nxt) : 4'd0;
          rec_frames = (ring_fill < cfg_cur.max_frames) ? 10'(ring_fill)
                                                        : cfg_cur.max_frames;
          spk_frames = 10'd1;
          sil_run = '0;
          r.recorded_count = rec_frames;
          r.speech_count = spk_frames;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [15:0] make_sample(input frame_kind_e k);
    int thr, m;
    thr = int'(cfg_cur.energy_threshold);
    case (k)
      K_QUIET: m = $urandom_range(0, (thr > 32767) ? 32767 : thr);
      K_LOUD: begin
        if (thr >= 32768) return 16'($urandom);
        m = $urandom_range(thr + 1, 32768);
      end
      K_EDGE_LO: m = thr;
      K_EDGE_HI: m = (thr >= 32768) ? 32768 : thr + 1;
      default: return 16'($urandom);
    endcase
    if (m >= 32768) return 16'sh8000;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("MISMATCH at result %0d: %s got %0d, expected %0d", res_count, what, got, want);
    mismatches++;
  endtask

  // Hold valid until the transfer, then either chain the next item or idle.
  task automatic send_sample(input evfg_pkg::in_t d, input bit typed,
                             input evfg_pkg::res_t want);
    evfg_pkg::res_t r;
    int gap;
    in_data <= d;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (gate_frame_step(d, r)) frame_results_q.push_back(typed ? want : r);
    gap = idle_len(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input int len, input frame_kind_e k, input bit by_count);
    evfg_pkg::in_t d;
    for (int i = 0; i < len; i++) begin
      d.sample = make_sample(k);
      d.last_in_frame = by_count ? 1'b0 : (i == len - 1);
      send_sample(d, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frame_results_q.size() > 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(input evfg_pkg::cfg_t c);
    logic [evfg_pkg::CFG_IDX_W-1:0] idx;
    cfg_cur = c;
    for (int i = 0; i <= int'(evfg_pkg::REG_FLUSH); i++) begin
      idx = evfg_pkg::CFG_IDX_W'(i);
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        evfg_pkg::REG_THRESHOLD:   cfg_wdata <= c.energy_threshold;
        evfg_pkg::REG_PREROLL:     cfg_wdata <= evfg_pkg::CFG_DATA_W'(c.preroll_frames);
        evfg_pkg::REG_SILENCE_LIM: cfg_wdata <= evfg_pkg::CFG_DATA_W'(c.silence_limit);
        evfg_pkg::REG_MAX_FRAMES:  cfg_wdata <= evfg_pkg::CFG_DATA_W'(c.max_frames);
        evfg_pkg::REG_MIN_SPEECH:  cfg_wdata <= evfg_pkg::CFG_DATA_W'(c.min_speech);
        default:                   cfg_wdata <= evfg_pkg::CFG_DATA_W'(c.flush_frames);
      endcase
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    evfg_pkg::res_t got, want;
    if (rst_ni && out_valid_o && out_ready) begin
      got = out_data_o;
      if (frame_results_q.size() == 0) begin
        flag_mismatch("unexpected result, event_res", got.event_res, -1);
      end else begin
        want = frame_results_q.pop_front();
        if (got.event_res !== want.event_res)
          flag_mismatch("event_res", got.event_res, want.event_res);
        if (got.frame_energy !== want.frame_energy)
          flag_mismatch("frame_energy", got.frame_energy, want.frame_energy);
        if (got.is_speech !== want.is_speech)
          flag_mismatch("is_speech", got.is_speech, want.is_speech);
        if (got.keep_frame !== want.keep_frame)
          flag_mismatch("keep_frame", got.keep_frame, want.keep_frame);
        if (got.ring_slot !== want.ring_slot)
          flag_mismatch("ring_slot", got.ring_slot, want.ring_slot);
        if (got.preroll_count !== want.preroll_count)
          flag_mismatch("preroll_count", got.preroll_count, want.preroll_count);
        if (got.oldest_slot !== want.oldest_slot)
          flag_mismatch("oldest_slot", got.oldest_slot, want.oldest_slot);
        if (got.recorded_count !== want.recorded_count)
          flag_mismatch("recorded_count", got.recorded_count, want.recorded_count);
        if (got.speech_count !== want.speech_count)
          flag_mismatch("speech_count", got.speech_count, want.speech_count);
        if (got.accepted !== want.accepted)
          flag_mismatch("accepted", got.accepted, want.accepted);
      end
      res_count++;
    end
  end

  // Result side: random stalls, plus one long hold-off while input streams.
  initial begin
    int run, stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_ready <= 1'b1;
      run = $urandom_range(1, 10);
      repeat (run) @(negedge clk_i);
      if (!held && res_count >= 30 && in_valid) begin
        held = 1'b1;
        stall = 400;
      end else begin
        stall = idle_len(rx_calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    int items, burst, len, r;
    frame_kind_e kind;
    evfg_pkg::cfg_t c;
    cfg_cur = '{evfg_pkg::RST_THRESHOLD, evfg_pkg::RST_PREROLL,
                evfg_pkg::RST_SILENCE_LIM, evfg_pkg::RST_MAX_FRAMES,
                evfg_pkg::RST_MIN_SPEECH, evfg_pkg::RST_FLUSH};
    gate_mode = evfg_pkg::MODE_IDLE;
    acc_sum = '0;
    acc_cnt = '0;
    ring_ptr = '0;
    ring_fill = '0;
    rec_frames = '0;
    sil_run = '0;
    spk_frames = '0;
    flush_left = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_sample(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < FIXED_PHASES) begin
        c = phase_cfg[p];
      end else begin
        c.energy_threshold = 16'($urandom_range(0, 4000));
        c.preroll_frames = 5'($urandom_range(1, evfg_pkg::PREROLL_DEPTH));
        c.silence_limit = 10'($urandom_range(1, 6));
        c.max_frames = 10'($urandom_range(16, 40));
        c.min_speech = 10'($urandom_range(0, 5));
        c.flush_frames = 8'($urandom_range(0, 8));
      end
      write_cfg(c);
      if (p == 2) send_frame(evfg_pkg::FRAME_SAMPLES, K_NOISE, 1'b1);
      items = 0;
      while (items < 30) begin
        r = $urandom_range(0, 99);
        kind = (r < 45) ? K_LOUD : (r < 80) ? K_QUIET : (r < 88) ? K_EDGE_LO :
               (r < 94) ? K_EDGE_HI : K_NOISE;
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          r = $urandom_range(0, 99);
          len = (r < 70) ? $urandom_range(1, 4) :
                (r < 93) ? $urandom_range(5, 12) : $urandom_range(20, 40);
          send_frame(len, kind, 1'b0);
          items += len;
        end
      end
    end
    drain();

    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
